### hw/rtl/css_pkg.sv
// Package for the cosine similarity checksum block: sizes, codes, states and
// control structs. Used by every file of the block; depends on nothing.
package css_pkg;

   localparam int CSS_MAX_DIMS = 1024;
   localparam int CSS_MAX_AXES = 64;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_IN_USE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXES_IN_USE = 8'd1;

   localparam logic CMD_AXIS  = 1'b0;
   localparam logic CMD_EMBED = 1'b1;

   localparam logic [63:0] Q_ONE = 64'd1073741824;
   localparam int ROOT_STEPS = 32;
   localparam int DIV_STEPS  = 30;

   typedef enum logic [1:0] {
      MAC_EMBED_SQ,
      MAC_AXIS_SQ,
      MAC_DOT
   } mac_mode_type;

   typedef enum logic {
      RD_ROOT,
      RD_DIV
   } rd_mode_type;

   typedef struct packed {
      logic         start;
      mac_mode_type mode;
   } mac_ctl_type;

   typedef struct packed {
      logic        start;
      rd_mode_type mode;
   } rd_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AX_SUMSQ,
      ST_AX_ROOT,
      ST_EM_SUMSQ,
      ST_EM_ROOT,
      ST_NORM_RD,
      ST_DEN,
      ST_CHECK,
      ST_DOT,
      ST_DIV_GO,
      ST_DIV,
      ST_ACC,
      ST_EMIT
   } state_type;

endpackage

### hw/rtl/css_channels.sv
// Handshake channel interfaces for requests, results and register writes.
// Depends on css_pkg.
interface css_req_if import css_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [5:0]         axis_index;
   logic [9:0]         element_index;
   logic signed [31:0] value;
   modport source (output valid, cmd, axis_index, element_index, value, input ready);
   modport sink (input valid, cmd, axis_index, element_index, value, output ready);
endinterface

interface css_rsp_if import css_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [63:0] checksum;
   logic               skipped;
   modport source (output valid, checksum, skipped, input ready);
   modport sink (input valid, checksum, skipped, output ready);
endinterface

interface css_csr_if import css_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/css_mac.sv
// Element stores and the shared multiply-accumulate pipeline: sums of
// squares and dot products over one vector. Depends on css_pkg.
module css_mac
   import css_pkg::*;
#(
   parameter int MAX_DIMS = CSS_MAX_DIMS,
   parameter int MAX_AXES = CSS_MAX_AXES,
   localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
   localparam int AXW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1,
   localparam int DCW = $clog2(MAX_DIMS + 1),
   localparam int DEPTH = MAX_DIMS * MAX_AXES,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  mac_ctl_type        ctl,
   input  logic [AXW-1:0]     row,
   input  logic [DCW-1:0]     dims,
   input  logic               wr_axis,
   input  logic               wr_embed,
   input  logic [AXW-1:0]     wr_row,
   input  logic [DIW-1:0]     wr_el,
   input  logic signed [31:0] wr_value,
   output logic               done,
   output logic signed [63:0] acc
);

   logic signed [31:0] axis_store [DEPTH];
   logic signed [31:0] embed_buffer [MAX_DIMS];

   logic               run_ff, run_in;
   logic [DCW-1:0]     cnt_ff, cnt_in;
   mac_mode_type       mode_ff, mode_in;
   logic [AXW-1:0]     row_ff, row_in;
   logic               v1_ff, v1_in, l1_ff, l1_in;
   logic               v2_ff, l2_ff;
   logic signed [31:0] a_rd_ff, e_rd_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   logic               done_ff;
   logic signed [31:0] x, y;
   logic [AW-1:0]      rd_addr, wr_addr;

   assign rd_addr = AW'(row_ff) * AW'(MAX_DIMS) + AW'(cnt_ff[DIW-1:0]);
   assign wr_addr = AW'(wr_row) * AW'(MAX_DIMS) + AW'(wr_el);

   always_ff @(posedge clock) begin
      if (wr_axis) begin
         axis_store[wr_addr] <= wr_value;
      end
      if (wr_embed) begin
         embed_buffer[wr_el] <= wr_value;
      end
      a_rd_ff <= axis_store[rd_addr];
      e_rd_ff <= embed_buffer[cnt_ff[DIW-1:0]];
   end

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      row_in  = row_ff;
      v1_in   = 1'b0;
      l1_in   = 1'b0;
      if (ctl.start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         mode_in = ctl.mode;
         row_in  = row;
      end else if (run_ff) begin
         v1_in = 1'b1;
         l1_in = (cnt_ff == dims - DCW'(1));
         if (l1_in) begin
            run_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + DCW'(1);
         end
      end
   end

   always_comb begin
      x = (mode_ff == MAC_AXIS_SQ) ? a_rd_ff : e_rd_ff;
      y = (mode_ff == MAC_EMBED_SQ) ? e_rd_ff : a_rd_ff;
      prod_in = x * y;
      acc_in = acc_ff;
      if (ctl.start) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + (prod_ff >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         v1_ff   <= 1'b0;
         l1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         l2_ff   <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         mode_ff <= MAC_EMBED_SQ;
         row_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         v1_ff   <= v1_in;
         l1_ff   <= l1_in;
         v2_ff   <= v1_ff;
         l2_ff   <= l1_ff;
         done_ff <= v2_ff & l2_ff;
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
         row_ff  <= row_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

### hw/rtl/css_rootdiv.sv
// Shared shift-subtract unit: integer square root of a sum of squares, and
// the fractional quotient of a cosine, one bit per cycle. Depends on css_pkg.
module css_rootdiv
   import css_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  rd_ctl_type  ctl,
   input  logic [63:0] opa,
   input  logic [63:0] opb,
   output logic        done,
   output logic [31:0] result
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   rd_mode_type mode_ff, mode_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] cmp_a, cmp_b, diff;
   logic        ge;

   always_comb begin
      if (mode_ff == RD_ROOT) begin
         cmp_a = rem_ff;
         cmp_b = res_ff + bit_ff;
      end else begin
         cmp_a = {rem_ff[62:0], 1'b0};
         cmp_b = bit_ff;
      end
      ge   = (cmp_a >= cmp_b);
      diff = cmp_a - cmp_b;
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (ctl.start) begin
         mode_in = ctl.mode;
         rem_in  = opa;
         res_in  = '0;
         if (ctl.mode == RD_ROOT) begin
            bit_in = 64'd1 << 62;
            cnt_in = 6'(ROOT_STEPS);
            run_in = 1'b1;
         end else if (opa >= opb) begin
            res_in  = Q_ONE;
            done_in = 1'b1;
         end else begin
            bit_in = opb;
            cnt_in = 6'(DIV_STEPS);
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         if (mode_ff == RD_ROOT) begin
            if (ge) begin
               rem_in = diff;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end else begin
            rem_in = ge ? diff : cmp_a;
            res_in = {res_ff[62:0], ge};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         mode_ff <= RD_ROOT;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done   = done_ff;
   assign result = res_ff[31:0];

endmodule

### hw/rtl/cosine_similarity_sum.sv
// Cosine similarity checksum: top level with the sequencer, the axis norm
// store and the running sum. Depends on css_pkg, the channel interfaces,
// css_mac and css_rootdiv.
//
// Usage: write dims_in_use (index 0) and axes_in_use (index 1) on csr_bus,
// which is always ready. Load axis elements on req_bus with cmd 0, then
// stream embedding elements with cmd 1. An element that does not end a
// vector leaves req_bus ready. An axis element at position dims_in_use-1
// starts the multiply-accumulate pass over the stored row, then 32 square
// root steps in the shared shift-subtract unit. An embedding's last
// element does the same for its norm; unless that norm is zero, each axis
// in use then gets a dot product pass, 30 quotient steps and an add; a
// zero norm product skips the pass and the steps, and a dot product
// magnitude not below the norm product gives Q_ONE without steps. req_bus
// is not ready while that work runs. The result waits in an output
// register on rsp_bus; a stalled receiver holds the block only
// when the next result is ready to load. Reset clears the registers to 1,
// the checksum to zero and any pending result; element stores keep
// whatever they hold until written.
module cosine_similarity_sum
   import css_pkg::*;
#(
   parameter int MAX_DIMS = CSS_MAX_DIMS,
   parameter int MAX_AXES = CSS_MAX_AXES
) (
   input logic     clock,
   input logic     reset,
   css_req_if.sink   req_bus,
   css_rsp_if.source rsp_bus,
   css_csr_if.sink   csr_bus
);

   localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int AXW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
   localparam int DCW = $clog2(MAX_DIMS + 1);
   localparam int ACW = $clog2(MAX_AXES + 1);

   state_type          state_ff, state_in;
   logic [10:0]        dims_ff;
   logic [6:0]         axes_ff;
   logic [DCW-1:0]     dims_eff;
   logic [ACW-1:0]     axes_eff;
   logic [AXW-1:0]     ax_ff, ax_in;
   logic [ACW-1:0]     j_ff, j_in;
   logic [31:0]        ne_ff, ne_in;
   logic [31:0]        axis_norm [MAX_AXES];
   logic [31:0]        an_rd_ff;
   logic               norm_we;
   logic [63:0]        den_ff, den_in;
   logic [63:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [31:0]        q_ff, q_in;
   logic signed [63:0] sum_ff, sum_in;
   logic               skip_ff, skip_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [63:0] rsp_sum_ff;
   logic               rsp_skip_ff;
   logic               load_rsp;

   logic               accept, el_ok, ax_ok, is_end;
   logic               wr_axis, wr_embed;
   mac_ctl_type        mac_ctl;
   logic               mac_done;
   logic signed [63:0] mac_acc;
   rd_ctl_type         rd_ctl;
   logic [63:0]        rd_opa, rd_opb;
   logic               rd_done;
   logic [31:0]        rd_result;
   logic signed [63:0] cos;
   logic signed [64:0] sum_wide;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= 11'd1;
         axes_ff <= 7'd1;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == CSR_DIMS_IN_USE) begin
            dims_ff <= csr_bus.data[10:0];
         end else if (csr_bus.index == CSR_AXES_IN_USE) begin
            axes_ff <= csr_bus.data[6:0];
         end
      end
   end

   always_comb begin
      if (dims_ff == 11'd0) begin
         dims_eff = DCW'(1);
      end else if (32'(dims_ff) > 32'(MAX_DIMS)) begin
         dims_eff = DCW'(MAX_DIMS);
      end else begin
         dims_eff = DCW'(dims_ff);
      end
      if (axes_ff == 7'd0) begin
         axes_eff = ACW'(1);
      end else if (32'(axes_ff) > 32'(MAX_AXES)) begin
         axes_eff = ACW'(MAX_AXES);
      end else begin
         axes_eff = ACW'(axes_ff);
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept   = req_bus.valid & req_bus.ready;
   assign el_ok    = (32'(req_bus.element_index) < 32'(MAX_DIMS));
   assign ax_ok    = (32'(req_bus.axis_index) < 32'(MAX_AXES));
   assign is_end   = (32'(req_bus.element_index) == 32'(dims_eff) - 32'd1);
   assign wr_axis  = accept & el_ok & ax_ok & (req_bus.cmd == CMD_AXIS);
   assign wr_embed = accept & el_ok & (req_bus.cmd == CMD_EMBED);

   css_mac #(.MAX_DIMS(MAX_DIMS), .MAX_AXES(MAX_AXES)) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .row      ((state_ff == ST_CHECK) ? j_ff[AXW-1:0] : AXW'(req_bus.axis_index)),
      .dims     (dims_eff),
      .wr_axis  (wr_axis),
      .wr_embed (wr_embed),
      .wr_row   (AXW'(req_bus.axis_index)),
      .wr_el    (DIW'(req_bus.element_index)),
      .wr_value (req_bus.value),
      .done     (mac_done),
      .acc      (mac_acc)
   );

   css_rootdiv u_rootdiv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (rd_ctl),
      .opa    (rd_opa),
      .opb    (rd_opb),
      .done   (rd_done),
      .result (rd_result)
   );

   always_ff @(posedge clock) begin
      if (norm_we) begin
         axis_norm[ax_ff] <= rd_result;
      end
      an_rd_ff <= axis_norm[j_ff[AXW-1:0]];
   end

   assign cos      = neg_ff ? -$signed(64'(q_ff)) : $signed(64'(q_ff));
   assign sum_wide = {sum_ff[63], sum_ff} + {cos[63], cos};
   assign load_rsp = (state_ff == ST_EMIT) & (~rsp_valid_ff | rsp_bus.ready);

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      j_in         = j_ff;
      ne_in        = ne_ff;
      den_in       = den_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      q_in         = q_ff;
      sum_in       = sum_ff;
      skip_in      = skip_ff;
      norm_we      = 1'b0;
      mac_ctl      = '{start: 1'b0, mode: MAC_EMBED_SQ};
      rd_ctl       = '{start: 1'b0, mode: RD_ROOT};
      rd_opa       = mag_ff;
      rd_opb       = den_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      case (state_ff)
         ST_IDLE: begin
            ax_in = AXW'(req_bus.axis_index);
            if (wr_axis & is_end) begin
               mac_ctl  = '{start: 1'b1, mode: MAC_AXIS_SQ};
               state_in = ST_AX_SUMSQ;
            end else if (wr_embed & is_end) begin
               mac_ctl  = '{start: 1'b1, mode: MAC_EMBED_SQ};
               state_in = ST_EM_SUMSQ;
            end
         end
         ST_AX_SUMSQ: begin
            if (mac_done) begin
               rd_ctl   = '{start: 1'b1, mode: RD_ROOT};
               rd_opa   = mac_acc;
               state_in = ST_AX_ROOT;
            end
         end
         ST_AX_ROOT: begin
            if (rd_done) begin
               norm_we  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EM_SUMSQ: begin
            if (mac_done) begin
               rd_ctl   = '{start: 1'b1, mode: RD_ROOT};
               rd_opa   = mac_acc;
               state_in = ST_EM_ROOT;
            end
         end
         ST_EM_ROOT: begin
            if (rd_done) begin
               ne_in   = rd_result;
               j_in    = '0;
               skip_in = (rd_result == 32'd0);
               state_in = (rd_result == 32'd0) ? ST_EMIT : ST_NORM_RD;
            end
         end
         ST_NORM_RD: begin
            state_in = ST_DEN;
         end
         ST_DEN: begin
            den_in   = 64'(ne_ff) * 64'(an_rd_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (den_ff == 64'd0) begin
               state_in = ST_ACC;
               q_in     = '0;
               neg_in   = 1'b0;
            end else begin
               mac_ctl  = '{start: 1'b1, mode: MAC_DOT};
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            if (mac_done) begin
               neg_in   = mac_acc[63];
               mag_in   = mac_acc[63] ? 64'(-mac_acc) : 64'(mac_acc);
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            rd_ctl   = '{start: 1'b1, mode: RD_DIV};
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rd_done) begin
               q_in     = rd_result;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (sum_wide[64] != sum_wide[63]) begin
               sum_in = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
               sum_in = sum_wide[63:0];
            end
            if (j_ff + ACW'(1) >= axes_eff) begin
               state_in = ST_EMIT;
            end else begin
               j_in     = j_ff + ACW'(1);
               state_in = ST_NORM_RD;
            end
         end
         ST_EMIT: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
         ax_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         j_ff         <= j_in;
         ax_ff        <= ax_in;
      end
      ne_ff   <= ne_in;
      den_ff  <= den_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      q_ff    <= q_in;
      skip_ff <= skip_in;
      if (load_rsp) begin
         rsp_sum_ff  <= sum_ff;
         rsp_skip_ff <= skip_ff;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.checksum = rsp_sum_ff;
   assign rsp_bus.skipped  = rsp_skip_ff;

endmodule
